// ===== rtl/core/lztb_pkg.sv =====
// Shared types and constants for the tag-bit LZ decompressor.
`default_nettype none
package lztb_pkg;

    localparam int unsigned WINDOW_BYTES_DEF = 65536;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_FEED  = 2'd1;
    localparam logic [1:0] OP_DRAIN = 2'd2;

    localparam logic [2:0] ST_ACCEPTED = 3'd0;
    localparam logic [2:0] ST_BYTE     = 3'd1;
    localparam logic [2:0] ST_NEED     = 3'd2;
    localparam logic [2:0] ST_FINISHED = 3'd3;
    localparam logic [2:0] ST_ERROR    = 3'd4;

    localparam logic [31:0] CLS0_C1 = 32'hFFFFC060;
    localparam logic [31:0] CLS0_C2 = 32'hFFFFFC60;
    localparam logic [31:0] CLS1_C1 = 32'hFFFF8180;
    localparam logic [31:0] CLS1_C2 = 32'hFFFFF980;
    localparam logic [31:0] CLS2_C1 = 32'hFFFF8300;
    localparam logic [31:0] CLS2_C2 = 32'hFFFFFB00;
    localparam logic [23:0] CLASS_LIMIT_A = 24'h010000;
    localparam logic [23:0] CLASS_LIMIT_B = 24'h040000;
    localparam logic [31:0] OFS_LIMIT = 32'h3FFFFFFF;

    typedef enum logic [3:0] {
        PH_IDLE, PH_FIRST, PH_TAG, PH_LIT, PH_OFS_A, PH_OFS_B, PH_OFS_BITS,
        PH_LEN2_A, PH_LEN2_B, PH_LEN_A, PH_LEN_B, PH_COPY, PH_DONE, PH_ERROR
    } phase_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic       start;     // arm a new section
        logic       feed;      // load held byte
        logic       step;      // run one decode step
        logic       rd_issue;  // issue history read for copy
        logic       copy_emit; // emit history read data
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic       done;      // step produced a result
        logic [2:0] status;
        logic [7:0] obyte;
        logic       last;
        logic       copy_next; // next step is a history copy
    } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/lztb_ctrl.sv =====
// Controller state machine: sequences drain steps and the output register.
`default_nettype none
module lztb_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [1:0]          operation,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [2:0]               status,
    output logic [7:0]               out_byte,
    output logic                     last,
    output lztb_pkg::cmd_t           cmd,
    input  wire lztb_pkg::dp_stat_t  dstat
);
    import lztb_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_STEP = 4'b0010,
        S_RD   = 4'b0100,
        S_CP   = 4'b1000
    } cstate_t;

    cstate_t    state_reg, state_next;
    logic       ov_reg, ov_next;
    logic [2:0] st_reg, st_next;
    logic [7:0] ob_reg, ob_next;
    logic       lt_reg, lt_next;
    logic       accept;

    assign in_ready = (state_reg == S_IDLE) && (!ov_reg || out_ready);
    assign accept = in_valid && in_ready;
    assign out_valid = ov_reg;
    assign status = st_reg;
    assign out_byte = ob_reg;
    assign last = lt_reg;

    always_comb
    begin
        state_next = state_reg;
        ov_next = ov_reg && !out_ready;
        st_next = st_reg;
        ob_next = ob_reg;
        lt_next = lt_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (operation == OP_DRAIN)
                    begin
                        state_next = dstat.copy_next ? S_RD : S_STEP;
                    end
                    else
                    begin
                        cmd.start = (operation == OP_START);
                        cmd.feed = (operation == OP_FEED);
                        ov_next = 1'b1;
                        st_next = ST_ACCEPTED;
                        ob_next = '0;
                        lt_next = 1'b0;
                    end
                end
            end
            S_STEP:
            begin
                cmd.step = 1'b1;
                if (dstat.done)
                begin
                    state_next = S_IDLE;
                    ov_next = 1'b1;
                    st_next = dstat.status;
                    ob_next = dstat.obyte;
                    lt_next = dstat.last;
                end
                else if (dstat.copy_next)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next = S_CP;
            end
            S_CP:
            begin
                cmd.copy_emit = 1'b1;
                state_next = S_IDLE;
                ov_next = 1'b1;
                st_next = dstat.status;
                ob_next = dstat.obyte;
                lt_next = dstat.last;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg <= 1'b0;
            st_reg <= ST_ACCEPTED;
            ob_reg <= '0;
            lt_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
            st_reg <= st_next;
            ob_reg <= ob_next;
            lt_reg <= lt_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/lztb_dp.sv =====
// Datapath: bit fetch, gamma decode, match check and history window.
`default_nettype none
module lztb_dp #(
    parameter int unsigned WINDOW_BYTES = lztb_pkg::WINDOW_BYTES_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [23:0]         total_size,
    input  wire logic [7:0]          compressed_byte,
    input  wire lztb_pkg::cmd_t      cmd,
    output lztb_pkg::dp_stat_t       dstat
);
    import lztb_pkg::*;

    localparam int AW = (WINDOW_BYTES > 1) ? $clog2(WINDOW_BYTES) : 1;
    localparam logic [32:0] WIN33 = 33'(WINDOW_BYTES);
    localparam logic [AW:0] WINA = (AW+1)'(WINDOW_BYTES);

    logic [7:0]  mem [WINDOW_BYTES];
    logic [7:0]  rd_reg;

    phase_t      ph_reg, ph_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic [7:0]  tag_reg, tag_next;
    logic [23:0] rem_reg, rem_next;
    logic [31:0] prev_reg, prev_next;
    logic [31:0] mo_reg, mo_next;
    logic [31:0] ml_reg, ml_next;
    logic [7:0]  hv_reg, hv_next;
    logic        hvld_reg, hvld_next;
    logic [3:0]  ob_reg, ob_next;
    logic [31:0] c1_reg, c1_next, c2_reg, c2_next;
    logic [1:0]  bon_reg, bon_next;

    logic        we;
    logic [7:0]  wdata;
    logic        have_bit, bit_v;
    logic [7:0]  tag_f;
    logic        hvld_f;
    logic [31:0] len_b;
    logic [31:0] nx, mo_sh, ml_fin;
    logic [AW:0] src_sum;
    logic [AW-1:0] src;
    logic [23:0] rem_dec;
    logic [AW-1:0] wp_inc;

    assign rem_dec = rem_reg - 24'd1;
    assign wp_inc = ({1'b0, wp_reg} + 1'b1 >= WINA) ? '0 : wp_reg + 1'b1;
    assign src_sum = ({1'b0, wp_reg} >= (AW+1)'(mo_reg)) ?
                     ({1'b0, wp_reg} - (AW+1)'(mo_reg)) :
                     ({1'b0, wp_reg} + WINA - (AW+1)'(mo_reg));
    assign src = src_sum[AW-1:0];

    // bit fetch with sentinel refill
    always_comb
    begin
        tag_f = tag_reg;
        hvld_f = hvld_reg;
        have_bit = 1'b1;
        bit_v = tag_reg[7];
        if (tag_reg[6:0] == 7'd0)
        begin
            if (!hvld_reg)
            begin
                have_bit = 1'b0;
            end
            else
            begin
                hvld_f = 1'b0;
                bit_v = hv_reg[7];
                tag_f = {hv_reg[6:0], 1'b1};
            end
        end
        else
        begin
            tag_f = {tag_reg[6:0], 1'b0};
        end
    end

    assign nx = ~mo_sh;
    assign mo_sh = {mo_reg[30:0], bit_v};

    always_comb
    begin
        ph_next = ph_reg; wp_next = wp_reg; tag_next = tag_reg; rem_next = rem_reg;
        prev_next = prev_reg; mo_next = mo_reg; ml_next = ml_reg; hv_next = hv_reg;
        hvld_next = hvld_reg; ob_next = ob_reg; c1_next = c1_reg; c2_next = c2_reg;
        bon_next = bon_reg;
        we = 1'b0; wdata = hv_reg;
        dstat = '0;
        dstat.copy_next = (ph_reg == PH_COPY);
        len_b = '0;
        ml_fin = '0;
        if (cmd.start)
        begin
            rem_next = total_size; tag_next = '0; prev_next = '0; mo_next = '0;
            ml_next = '0; bon_next = '0; hvld_next = 1'b0; hv_next = '0;
            if (total_size < CLASS_LIMIT_A)
            begin
                ob_next = 4'd5; c1_next = CLS0_C1; c2_next = CLS0_C2;
            end
            else if (total_size < CLASS_LIMIT_B)
            begin
                ob_next = 4'd7; c1_next = CLS1_C1; c2_next = CLS1_C2;
            end
            else
            begin
                ob_next = 4'd8; c1_next = CLS2_C1; c2_next = CLS2_C2;
            end
            ph_next = (total_size == 24'd0) ? PH_DONE : PH_FIRST;
        end
        else if (cmd.feed)
        begin
            if (!hvld_reg)
            begin
                hv_next = compressed_byte;
                hvld_next = 1'b1;
            end
        end
        else if (cmd.copy_emit)
        begin
            we = 1'b1; wdata = rd_reg;
            wp_next = wp_inc; rem_next = rem_dec;
            ml_next = ml_reg - 32'd1;
            dstat.done = 1'b1; dstat.status = ST_BYTE; dstat.obyte = rd_reg;
            if (rem_dec == 24'd0)
            begin
                dstat.last = 1'b1; ph_next = PH_DONE;
            end
            else if (ml_reg == 32'd1)
            begin
                ph_next = PH_TAG;
            end
        end
        else if (cmd.step)
        begin
            case (ph_reg)
                PH_IDLE, PH_DONE:
                begin
                    dstat.done = 1'b1; dstat.status = ST_FINISHED;
                end
                PH_ERROR:
                begin
                    dstat.done = 1'b1; dstat.status = ST_ERROR;
                end
                PH_COPY:
                begin
                    dstat.done = 1'b0;
                end
                PH_FIRST, PH_LIT:
                begin
                    dstat.done = 1'b1;
                    if (!hvld_reg)
                    begin
                        dstat.status = ST_NEED;
                    end
                    else
                    begin
                        hvld_next = 1'b0;
                        wdata = (ph_reg == PH_LIT) ? (hv_reg ^ rem_reg[7:0]) : hv_reg;
                        we = 1'b1; wp_next = wp_inc; rem_next = rem_dec;
                        dstat.status = ST_BYTE; dstat.obyte = wdata;
                        if (rem_dec == 24'd0)
                        begin
                            dstat.last = 1'b1; ph_next = PH_DONE;
                        end
                        else
                        begin
                            ph_next = PH_TAG;
                        end
                    end
                end
                default:
                begin
                    if (!have_bit)
                    begin
                        dstat.done = 1'b1; dstat.status = ST_NEED;
                    end
                    else
                    begin
                        tag_next = tag_f; hvld_next = hvld_f;
                        case (ph_reg)
                            PH_TAG:
                            begin
                                if (!bit_v) ph_next = PH_LIT;
                                else
                                begin
                                    mo_next = 32'd1; ph_next = PH_OFS_A;
                                end
                            end
                            PH_OFS_A:
                            begin
                                if (mo_reg >= OFS_LIMIT) ph_next = PH_ERROR;
                                else
                                begin
                                    mo_next = mo_sh; ph_next = PH_OFS_B;
                                end
                            end
                            PH_OFS_B:
                            begin
                                if (bit_v) ph_next = PH_OFS_A;
                                else
                                begin
                                    ml_next = '0;
                                    if (mo_reg == 32'd2)
                                    begin
                                        bon_next = '0; mo_next = prev_reg; ph_next = PH_LEN2_A;
                                    end
                                    else
                                    begin
                                        mo_next = mo_reg - 32'd3;
                                        ml_next = {28'd0, ob_reg};
                                        ph_next = PH_OFS_BITS;
                                    end
                                end
                            end
                            PH_OFS_BITS:
                            begin
                                if (mo_reg >= OFS_LIMIT) ph_next = PH_ERROR;
                                else
                                begin
                                    mo_next = mo_sh;
                                    ml_next = ml_reg - 32'd1;
                                    if (ml_reg == 32'd1)
                                    begin
                                        bon_next = 2'd1 + {1'b0, nx < c2_reg} + {1'b0, nx < c1_reg};
                                        mo_next = mo_sh + 32'd1;
                                        prev_next = mo_sh + 32'd1;
                                        ph_next = PH_LEN2_A;
                                    end
                                end
                            end
                            PH_LEN2_A:
                            begin
                                ml_next = {31'd0, bit_v}; ph_next = PH_LEN2_B;
                            end
                            PH_LEN2_B:
                            begin
                                len_b = {ml_reg[30:0], bit_v};
                                if (len_b == 32'd0)
                                begin
                                    ml_next = 32'd1; ph_next = PH_LEN_A;
                                end
                                else
                                begin
                                    ml_fin = (len_b > ~{30'd0, bon_reg}) ? '1 :
                                             len_b + {30'd0, bon_reg};
                                    ml_next = ml_fin;
                                    if (mo_reg == '0 || {1'b0, mo_reg} > WIN33 ||
                                        ml_fin > {8'd0, rem_reg})
                                        ph_next = PH_ERROR;
                                    else ph_next = PH_COPY;
                                end
                            end
                            PH_LEN_A:
                            begin
                                ml_next = ml_reg[31] ? '1 : {ml_reg[30:0], bit_v};
                                ph_next = PH_LEN_B;
                            end
                            PH_LEN_B:
                            begin
                                if (bit_v) ph_next = PH_LEN_A;
                                else
                                begin
                                    len_b = (ml_reg > 32'hFFFFFFFD) ? '1 : ml_reg + 32'd2;
                                    ml_fin = (len_b > ~{30'd0, bon_reg}) ? '1 :
                                             len_b + {30'd0, bon_reg};
                                    ml_next = ml_fin;
                                    if (mo_reg == '0 || {1'b0, mo_reg} > WIN33 ||
                                        ml_fin > {8'd0, rem_reg})
                                        ph_next = PH_ERROR;
                                    else ph_next = PH_COPY;
                                end
                            end
                            default: ph_next = PH_ERROR;
                        endcase
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (we) mem[wp_reg] <= wdata;
        if (cmd.rd_issue) rd_reg <= mem[src];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg <= PH_IDLE; wp_reg <= '0; tag_reg <= '0; rem_reg <= '0;
            prev_reg <= '0; mo_reg <= '0; ml_reg <= '0; hv_reg <= '0; hvld_reg <= 1'b0;
            ob_reg <= 4'd5; c1_reg <= CLS0_C1; c2_reg <= CLS0_C2; bon_reg <= '0;
        end
        else
        begin
            ph_reg <= ph_next; wp_reg <= wp_next; tag_reg <= tag_next; rem_reg <= rem_next;
            prev_reg <= prev_next; mo_reg <= mo_next; ml_reg <= ml_next; hv_reg <= hv_next;
            hvld_reg <= hvld_next; ob_reg <= ob_next; c1_reg <= c1_next; c2_reg <= c2_next;
            bon_reg <= bon_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/lz_tagbit_decompressor.sv =====
// Top level of the tag-bit LZ section decompressor.
//
//   channel   direction  handshake                 payload
//   in        sink       in_valid / in_ready        operation, compressed_byte
//   out       source     out_valid / out_ready      status, out_byte, last
//   cfg       sink       cfg_we (no wait)           cfg_wdata = total_size
//
// A start or feed transaction gets its accepted status in the cycle after it is taken.
// A drain transaction consumes one tag bit per cycle until a byte, a refill request or
// a final status comes out. One drain sees at most 15 tag bits (the rest of the current
// tag word and one refill from the held byte); a copied byte passes through the history
// read state and then the copy state (history read port).
// Reset clears all control state; the history window is left unset.
// A result stays in the output register until taken; the next transaction is taken
// in the same cycle the result leaves.
`default_nettype none
module lz_tagbit_decompressor #(
    parameter int unsigned WINDOW_BYTES = lztb_pkg::WINDOW_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  operation,
    input  wire logic [7:0]  compressed_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [7:0]       out_byte,
    output logic             last,
    input  wire logic        cfg_we,
    input  wire logic [23:0] cfg_wdata
);
    import lztb_pkg::*;

    logic [23:0] total_size_reg;
    cmd_t        cmd;
    dp_stat_t    dstat;

    // Hold the section length; the user must change it only while idle, the block does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) total_size_reg <= 24'd1;
        else if (cfg_we) total_size_reg <= cfg_wdata;
    end

    lztb_ctrl u_ctrl (
        .clk, .rst_n, .in_valid, .in_ready, .operation, .out_valid, .out_ready,
        .status, .out_byte, .last, .cmd, .dstat
    );

    lztb_dp #(.WINDOW_BYTES(WINDOW_BYTES)) u_dp (
        .clk, .rst_n, .total_size(total_size_reg), .compressed_byte, .cmd, .dstat
    );
endmodule
`default_nettype wire

// ===== rtl/core/lztb_checker.sv =====
// Port-level checker for the decompressor, bound to the top level.
`default_nettype none
module lztb_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [2:0] status,
    input wire logic [7:0] out_byte,
    input wire logic       last
);
    import lztb_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_byte))
        else $error("result changed while stalled");
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_BYTE |-> out_byte == 8'd0 && !last)
        else $error("byte or last without byte status");
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_ERROR)
        else $error("bad status code");
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> !out_valid || out_ready)
        else $error("transaction taken while a result is stuck");
endmodule

bind lz_tagbit_decompressor lztb_checker u_chk (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .status, .out_byte, .last
);
`default_nettype wire
